[rtl/core/bresenham_line_pixel_generator_macros.svh]
// ----------------------------------------------------------------------------
// bresenham line pixel generator assertion macros
// clocked on aclk, disabled while aresetn is low
// ----------------------------------------------------------------------------
`ifndef BRESENHAM_LINE_PIXEL_GENERATOR_MACROS_SVH
`define BRESENHAM_LINE_PIXEL_GENERATOR_MACROS_SVH

// same-cycle implication
`define BLPG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BLPG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/blpg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blpg_pkg
// field widths, register indexes and command codes of the line generator
// ----------------------------------------------------------------------------
package blpg_pkg;

    localparam int X_W        = 9;
    localparam int Y_W        = 8;
    localparam int COLOR_W    = 16;
    localparam int OFFSET_W   = 18;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 56;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 9;
    localparam int Y_SHIFT    = 10;
    localparam int X_SHIFT    = 1;

    localparam logic [X_W-1:0] WIDTH_RESET  = 9'd320;
    localparam logic [Y_W-1:0] HEIGHT_RESET = 8'd240;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_SCREEN_WIDTH  = 1'b0,
        CFG_SCREEN_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef enum logic [0:0] {
        ACT_START = 1'b0,
        ACT_STEP  = 1'b1
    } action_t;

endpackage

[rtl/core/bresenham_line_pixel_generator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bresenham_line_pixel_generator
// Bresenham line engine: a start beat (tuser 0) loads two endpoints and a color
// if start x <= width and start y <= height as configured; each step beat
// (tuser 1) then emits one pixel with its coordinates, framebuffer offset
// ((y << 10) | (x << 1)), color and tlast on the final endpoint. Every beat is
// handled by the error-term update between the line state and the output
// register, so the block takes one beat per clock while the output is not
// stalled; a step's pixel appears on the output in the cycle after the step is
// taken. A start never yields an output beat; a step while no line is active is
// dropped. The input is ready whenever the output register is empty or being drained.
// ----------------------------------------------------------------------------
`include "bresenham_line_pixel_generator_macros.svh"

module bresenham_line_pixel_generator #(
    parameter int COORD_BITS = 9
) (
    input  logic aclk,
    input  logic aresetn,

    input  logic                              cfg_wr_en,
    input  logic [blpg_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [blpg_pkg::CFG_DATA_W-1:0]   cfg_wdata,

    input  logic                              s_tvalid,
    output logic                              s_tready,
    // start_x, start_y, end_x, end_y, line_color
    input  logic [blpg_pkg::IN_TDATA_W-1:0]   s_tdata,
    // action
    input  logic                              s_tuser,

    output logic                              m_tvalid,
    input  logic                              m_tready,
    // pixel_x, pixel_y, pixel_offset, pixel_color
    output logic [blpg_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output logic                              m_tlast
);

    localparam int ERR_W = COORD_BITS + 2;
    localparam int CMP_W = COORD_BITS + blpg_pkg::X_W;

    // configuration
    logic [blpg_pkg::X_W-1:0] width_reg;
    logic [blpg_pkg::Y_W-1:0] height_reg;

    // line state
    logic                          busy_reg;
    logic                          steep_reg;
    logic [COORD_BITS-1:0]         major_pos_reg;
    logic [COORD_BITS-1:0]         major_end_reg;
    logic [COORD_BITS-1:0]         minor_pos_reg;
    logic                          minor_down_reg;
    logic [COORD_BITS-1:0]         major_delta_reg;
    logic [COORD_BITS-1:0]         minor_delta_reg;
    logic [ERR_W-1:0]              error_reg;
    logic [blpg_pkg::COLOR_W-1:0]  color_reg;

    // output register
    logic                               m_tvalid_reg;
    logic [blpg_pkg::OUT_TDATA_W-1:0]   m_tdata_reg;
    logic                               m_tlast_reg;

    // input beat fields
    logic [blpg_pkg::X_W-1:0]     in_x0, in_x1;
    logic [blpg_pkg::Y_W-1:0]     in_y0, in_y1;
    logic [blpg_pkg::COLOR_W-1:0] in_color;

    logic in_fire, start_fire, step_fire, in_range, pix_fire;

    logic [COORD_BITS-1:0] x0, y0, x1, y1, dx, dy;
    logic                  steep_c;
    logic [COORD_BITS-1:0] a0, a1, b0, b1, sa0, sa1, sb0, sb1;
    logic [COORD_BITS-1:0] major_delta_c, minor_delta_c;
    logic                  minor_down_c;
    logic [ERR_W-1:0]      err_init;

    logic                  last_c;
    logic [ERR_W-1:0]      err_sum;
    logic [COORD_BITS-1:0] px_c, py_c;
    logic [blpg_pkg::X_W-1:0]      pixel_x;
    logic [blpg_pkg::Y_W-1:0]      pixel_y;
    logic [blpg_pkg::OFFSET_W-1:0] pixel_offset;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    assign in_x0    = s_tdata[8:0];
    assign in_y0    = s_tdata[16:9];
    assign in_x1    = s_tdata[25:17];
    assign in_y1    = s_tdata[33:26];
    assign in_color = s_tdata[49:34];

    assign in_fire    = s_tvalid && s_tready;
    assign start_fire = in_fire && (s_tuser == blpg_pkg::ACT_START);
    assign step_fire  = in_fire && (s_tuser == blpg_pkg::ACT_STEP);
    assign pix_fire   = step_fire && busy_reg;

    // start setup
    assign x0 = COORD_BITS'({{COORD_BITS{1'b0}}, in_x0});
    assign y0 = COORD_BITS'({{COORD_BITS{1'b0}}, in_y0});
    assign x1 = COORD_BITS'({{COORD_BITS{1'b0}}, in_x1});
    assign y1 = COORD_BITS'({{COORD_BITS{1'b0}}, in_y1});

    assign in_range = (CMP_W'(x0) <= CMP_W'(width_reg)) && (CMP_W'(y0) <= CMP_W'(height_reg));

    assign dx      = (x1 >= x0) ? x1 - x0 : x0 - x1;
    assign dy      = (y1 >= y0) ? y1 - y0 : y0 - y1;
    assign steep_c = dy > dx;

    assign a0 = steep_c ? y0 : x0;
    assign b0 = steep_c ? x0 : y0;
    assign a1 = steep_c ? y1 : x1;
    assign b1 = steep_c ? x1 : y1;

    always_comb begin
        if (a0 > a1) begin
            sa0 = a1;
            sa1 = a0;
            sb0 = b1;
            sb1 = b0;
        end else begin
            sa0 = a0;
            sa1 = a1;
            sb0 = b0;
            sb1 = b1;
        end
    end

    assign major_delta_c = sa1 - sa0;
    assign minor_delta_c = (sb1 >= sb0) ? sb1 - sb0 : sb0 - sb1;
    assign minor_down_c  = !(sb0 < sb1);
    assign err_init      = ERR_W'(0) - ERR_W'(major_delta_c >> 1);

    // step
    assign last_c  = major_pos_reg == major_end_reg;
    assign err_sum = error_reg + ERR_W'(minor_delta_reg);
    assign px_c    = steep_reg ? minor_pos_reg : major_pos_reg;
    assign py_c    = steep_reg ? major_pos_reg : minor_pos_reg;
    assign pixel_x = blpg_pkg::X_W'({{blpg_pkg::X_W{1'b0}}, px_c});
    assign pixel_y = blpg_pkg::Y_W'({{blpg_pkg::Y_W{1'b0}}, py_c});
    assign pixel_offset = (blpg_pkg::OFFSET_W'(pixel_y) << blpg_pkg::Y_SHIFT)
                        | (blpg_pkg::OFFSET_W'(pixel_x) << blpg_pkg::X_SHIFT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= blpg_pkg::WIDTH_RESET;
            height_reg   <= blpg_pkg::HEIGHT_RESET;
            busy_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (blpg_pkg::cfg_reg_t'(cfg_addr))
                    blpg_pkg::CFG_SCREEN_WIDTH: begin
                        width_reg <= blpg_pkg::X_W'(cfg_wdata);
                    end
                    blpg_pkg::CFG_SCREEN_HEIGHT: begin
                        height_reg <= blpg_pkg::Y_W'(cfg_wdata);
                    end
                    default: begin
                    end
                endcase
            end

            if (pix_fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            if (start_fire && in_range) begin
                busy_reg        <= 1'b1;
                steep_reg       <= steep_c;
                major_pos_reg   <= sa0;
                major_end_reg   <= sa1;
                minor_pos_reg   <= sb0;
                minor_down_reg  <= minor_down_c;
                major_delta_reg <= major_delta_c;
                minor_delta_reg <= minor_delta_c;
                error_reg       <= err_init;
                color_reg       <= in_color;
            end else if (pix_fire) begin
                m_tlast_reg  <= last_c;
                m_tdata_reg  <= {5'b0, color_reg, pixel_offset, pixel_y, pixel_x};
                if (last_c) begin
                    busy_reg <= 1'b0;
                end else begin
                    major_pos_reg <= major_pos_reg + COORD_BITS'(1);
                    if (!err_sum[ERR_W-1]) begin
                        minor_pos_reg <= minor_down_reg ? minor_pos_reg - COORD_BITS'(1)
                                                        : minor_pos_reg + COORD_BITS'(1);
                        error_reg     <= err_sum - ERR_W'(major_delta_reg);
                    end else begin
                        error_reg     <= err_sum;
                    end
                end
            end
        end
    end

    `BLPG_ASSERT_NEXT(a_step_emits, pix_fire, m_tvalid_reg,
        "step on active line gave no beat")
    `BLPG_ASSERT_NOW(a_beat_from_step, $rose(m_tvalid_reg), $past(pix_fire),
        "beat without a step")
    `BLPG_ASSERT_NEXT(a_last_ends_line, pix_fire && last_c, !busy_reg,
        "line still active after last pixel")
    `BLPG_ASSERT_NOW(a_error_bound, busy_reg, error_reg[ERR_W-1] || (error_reg == ERR_W'(0)),
        "error term above zero")
    `BLPG_ASSERT_NOW(a_delta_order, busy_reg, minor_delta_reg <= major_delta_reg,
        "minor delta exceeds major delta")

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the line pixel generator. A short table of directed
// beats covers reset, the resolution limits, rejected starts, steps while idle
// and single-point lines. Random line sequences follow across several screen
// sizes. Every accepted pixel is checked against a Bresenham line tracer kept
// here, under random input bursts, output stalls and two long output hold-offs.
// ----------------------------------------------------------------------------
module testbench;

    typedef struct packed {
        logic [5:0]  pad;
        logic [15:0] color;
        logic [7:0]  ey;
        logic [8:0]  ex;
        logic [7:0]  sy;
        logic [8:0]  sx;
    } line_word_t;

    typedef struct packed {
        logic [4:0]  pad;
        logic [15:0] color;
        logic [17:0] offset;
        logic [7:0]  y;
        logic [8:0]  x;
    } pixel_word_t;

    typedef struct packed {
        logic [8:0]  x;
        logic [7:0]  y;
        logic [17:0] offset;
        logic [15:0] color;
        logic        last;
    } pixel_t;

    typedef struct {
        bit     fixed;
        bit     fixed_hit;
        pixel_t px;
    } beat_tag_t;

    typedef struct {
        blpg_pkg::action_t act;
        logic [8:0]  sx;
        logic [7:0]  sy;
        logic [8:0]  ex;
        logic [7:0]  ey;
        logic [15:0] color;
        bit          fixed;
        bit          fixed_hit;
        pixel_t      px;
    } dir_row_t;

    localparam int NUM_DIR = 24;
    localparam int NUM_PHASES = 6;
    localparam int BEATS_PER_PHASE = 290;

    logic                               aclk;
    logic                               aresetn;
    logic                               cfg_wr_en;
    logic [blpg_pkg::CFG_ADDR_W-1:0]    cfg_addr;
    logic [blpg_pkg::CFG_DATA_W-1:0]    cfg_wdata;
    logic                               s_tvalid;
    logic                               s_tready;
    logic [blpg_pkg::IN_TDATA_W-1:0]    s_tdata;   // start_x, start_y, end_x, end_y, line_color
    logic                               s_tuser;   // action
    logic                               m_tvalid;
    logic                               m_tready;
    logic [blpg_pkg::OUT_TDATA_W-1:0]   m_tdata;   // pixel_x, pixel_y, pixel_offset, pixel_color
    logic                               m_tlast;

    bresenham_line_pixel_generator u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // line tracer state
    int width_limit = int'(blpg_pkg::WIDTH_RESET);
    int height_limit = int'(blpg_pkg::HEIGHT_RESET);
    bit line_active = 0;
    bit line_steep = 0;
    int run_pos = 0;
    int run_end = 0;
    int side_pos = 0;
    bit side_dec = 0;
    int run_len = 0;
    int side_len = 0;
    int err_acc = 0;
    logic [15:0] held_color = '0;

    pixel_t    pixel_q[$];
    beat_tag_t beat_tags[$];
    int        fail_count = 0;
    int        burst_left = 0;
    int        hold_requests = 0;
    int        phase_beats = 0;
    dir_row_t  dir_rows [0:NUM_DIR-1];

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    function automatic int span(input int a, input int b);
        return (a > b) ? a - b : b - a;
    endfunction

    // returns 1 when the beat yields a pixel
    function automatic bit trace_beat(input blpg_pkg::action_t act, input line_word_t w,
                                      output pixel_t px);
        int x0, y0, x1, y1, a0, a1, b0, b1, t, px_x, px_y;
        px = '0;
        if (act == blpg_pkg::ACT_START) begin
            x0 = int'(w.sx);
            y0 = int'(w.sy);
            x1 = int'(w.ex);
            y1 = int'(w.ey);
            if (x0 > width_limit || y0 > height_limit) return 0;
            line_steep = span(y1, y0) > span(x1, x0);
            if (line_steep) begin
                a0 = y0; b0 = x0; a1 = y1; b1 = x1;
            end else begin
                a0 = x0; b0 = y0; a1 = x1; b1 = y1;
            end
            if (a0 > a1) begin
                t = a0; a0 = a1; a1 = t;
                t = b0; b0 = b1; b1 = t;
            end
            run_pos = a0;
            run_end = a1;
            side_pos = b0;
            side_dec = !(b0 < b1);
            run_len = a1 - a0;
            side_len = span(b1, b0);
            err_acc = -(run_len / 2);
            held_color = w.color;
            line_active = 1;
            return 0;
        end
        if (!line_active) return 0;
        px_x = (line_steep ? side_pos : run_pos) & 511;
        px_y = (line_steep ? run_pos : side_pos) & 255;
        px.x = px_x[8:0];
        px.y = px_y[7:0];
        px.offset = 18'((px_y << blpg_pkg::Y_SHIFT) | (px_x << blpg_pkg::X_SHIFT));
        px.color = held_color;
        px.last = (run_pos == run_end);
        if (px.last) begin
            line_active = 0;
        end else begin
            run_pos = (run_pos + 1) & 511;
            err_acc += side_len;
            if (err_acc >= 0) begin
                side_pos = (side_dec ? side_pos - 1 : side_pos + 1) & 511;
                err_acc -= run_len;
            end
        end
        return 1;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // scoreboard: outputs are checked before the same edge's input is traced
    always @(posedge aclk) begin
        pixel_t      want;
        pixel_t      traced;
        pixel_word_t got;
        beat_tag_t   tag;
        bit          hit;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (pixel_q.size() == 0) begin
                    $error("unexpected pixel beat x=%0d y=%0d", got.x, got.y);
                    fail_count++;
                end else begin
                    want = pixel_q.pop_front();
                    check_field("pixel_x", int'(want.x), int'(got.x));
                    check_field("pixel_y", int'(want.y), int'(got.y));
                    check_field("pixel_offset", int'(want.offset), int'(got.offset));
                    check_field("pixel_color", int'(want.color), int'(got.color));
                    check_field("last_pixel", int'(want.last), int'(m_tlast));
                end
            end
            if (s_tvalid && s_tready) begin
                tag = beat_tags.pop_front();
                hit = trace_beat(blpg_pkg::action_t'(s_tuser), line_word_t'(s_tdata), traced);
                if (tag.fixed) begin
                    if (tag.fixed_hit) pixel_q.push_back(tag.px);
                end else if (hit) begin
                    pixel_q.push_back(traced);
                end
            end
        end
    end

    // receiver: randomly reselected stall patterns, plus requested hold-offs
    initial begin
        int hold_served;
        int hold_left;
        int stall_mode;
        int cyc;
        hold_served = 0;
        hold_left = 0;
        stall_mode = 0;
        cyc = 0;
        m_tready = 1'b1;
        forever begin
            @(negedge aclk);
            cyc++;
            if (cyc % 50 == 0) stall_mode = int'($urandom_range(0, 3));
            if (hold_left == 0 && hold_served != hold_requests) begin
                hold_served++;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready = 1'b0;
            end else begin
                case (stall_mode)
                    0: m_tready = 1'b1;
                    1: m_tready = ($urandom_range(0, 3) != 0);
                    2: m_tready = 1'($urandom_range(0, 1));
                    default: m_tready = (cyc % 4 == 0);
                endcase
            end
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_beat(input blpg_pkg::action_t act, input line_word_t w,
                             input beat_tag_t tag);
        if (burst_left == 0) begin
            s_tvalid = 1'b0;
            if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 6)) @(negedge aclk);
            burst_left = int'($urandom_range(1, 24));
        end
        s_tvalid = 1'b1;
        s_tuser = act;
        s_tdata = w;
        beat_tags.push_back(tag);
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        burst_left--;
        phase_beats++;
    endtask

    task automatic send_traced(input blpg_pkg::action_t act, input line_word_t w);
        beat_tag_t tag;
        tag = '{fixed: 0, fixed_hit: 0, px: '0};
        send_beat(act, w, tag);
    endtask

    task automatic write_reg(input blpg_pkg::cfg_reg_t idx, input int value);
        cfg_wr_en = 1'b1;
        cfg_addr = idx;
        cfg_wdata = value[blpg_pkg::CFG_DATA_W-1:0];
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        case (idx)
            blpg_pkg::CFG_SCREEN_WIDTH:  width_limit = value & 511;
            blpg_pkg::CFG_SCREEN_HEIGHT: height_limit = value & 255;
            default: ;
        endcase
    endtask

    task automatic drain_pixels();
        s_tvalid = 1'b0;
        burst_left = 0;
        while (pixel_q.size() != 0 || beat_tags.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    function automatic int near_coord(input int base, input int top);
        int v;
        v = base + int'($urandom_range(0, 16)) - 8;
        if (v < 0) v = 0;
        if (v > top) v = top;
        return v;
    endfunction

    task automatic send_line();
        line_word_t w;
        int n;
        int steps;
        w = '0;
        w.sx = 9'($urandom_range(0, width_limit));
        w.sy = 8'($urandom_range(0, height_limit));
        if ($urandom_range(0, 39) == 0) begin
            w.ex = 9'($urandom_range(0, 511));
            w.ey = 8'($urandom_range(0, 255));
        end else begin
            w.ex = 9'(near_coord(int'(w.sx), 511));
            w.ey = 8'(near_coord(int'(w.sy), 255));
        end
        w.color = 16'($urandom_range(0, 65535));
        send_traced(blpg_pkg::ACT_START, w);
        n = span(int'(w.ex), int'(w.sx));
        if (span(int'(w.ey), int'(w.sy)) > n) n = span(int'(w.ey), int'(w.sy));
        n++;
        case ($urandom_range(0, 7))
            0: steps = int'($urandom_range(0, n - 1));
            1: steps = n + int'($urandom_range(1, 2));
            default: steps = n;
        endcase
        repeat (steps) begin
            w = '0;
            w[49:0] = 50'({$urandom, $urandom});
            send_traced(blpg_pkg::ACT_STEP, w);
        end
    endtask

    task automatic send_noise();
        line_word_t w;
        w = '0;
        w[49:0] = 50'({$urandom, $urandom});
        send_traced(blpg_pkg::action_t'($urandom_range(0, 1)), w);
    endtask

    initial begin
        #5ms;
        $display("** bresenham_line_pixel_generator: FAILED **");
        $finish;
    end

    initial begin
        line_word_t w;
        beat_tag_t  tag;
        int         wv;
        int         hv;

        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tuser = 1'b0;
        s_tdata = '0;

        dir_rows = '{
            '{blpg_pkg::ACT_STEP,  9'd0,   8'd0,   9'd0,   8'd0,   16'h0000, 1, 0, '0},
            '{blpg_pkg::ACT_START, 9'd0,   8'd0,   9'd0,   8'd0,   16'hFFFF, 1, 0, '0},
            '{blpg_pkg::ACT_STEP,  9'd0,   8'd0,   9'd0,   8'd0,   16'h0000, 1, 1,
              '{9'd0, 8'd0, 18'd0, 16'hFFFF, 1'b1}},
            '{blpg_pkg::ACT_STEP,  9'd0,   8'd0,   9'd0,   8'd0,   16'h0000, 1, 0, '0},
            '{blpg_pkg::ACT_START, 9'd320, 8'd240, 9'd320, 8'd240, 16'h0000, 1, 0, '0},
            '{blpg_pkg::ACT_STEP,  9'd511, 8'd255, 9'd511, 8'd255, 16'hFFFF, 1, 1,
              '{9'd320, 8'd240, 18'd246400, 16'h0000, 1'b1}},
            // start just outside the screen is dropped
            '{blpg_pkg::ACT_START, 9'd321, 8'd0,   9'd0,   8'd0,   16'h1111, 1, 0, '0},
            '{blpg_pkg::ACT_STEP,  9'd0,   8'd0,   9'd0,   8'd0,   16'h0000, 1, 0, '0},
            '{blpg_pkg::ACT_START, 9'd0,   8'd241, 9'd0,   8'd0,   16'h2222, 1, 0, '0},
            '{blpg_pkg::ACT_STEP,  9'd0,   8'd0,   9'd0,   8'd0,   16'h0000, 1, 0, '0},
            '{blpg_pkg::ACT_START, 9'd0,   8'd0,   9'd5,   8'd2,   16'h1234, 0, 0, '0},
            '{blpg_pkg::ACT_STEP,  9'd0,   8'd0,   9'd0,   8'd0,   16'h0000, 0, 0, '0},
            '{blpg_pkg::ACT_STEP,  9'd0,   8'd0,   9'd0,   8'd0,   16'h0000, 0, 0, '0},
            '{blpg_pkg::ACT_STEP,  9'd0,   8'd0,   9'd0,   8'd0,   16'h0000, 0, 0, '0},
            // steep descending line abandons the one in progress
            '{blpg_pkg::ACT_START, 9'd10,  8'd200, 9'd12,  8'd100, 16'hABCD, 0, 0, '0},
            '{blpg_pkg::ACT_STEP,  9'd0,   8'd0,   9'd0,   8'd0,   16'h0000, 0, 0, '0},
            '{blpg_pkg::ACT_STEP,  9'd0,   8'd0,   9'd0,   8'd0,   16'h0000, 0, 0, '0},
            '{blpg_pkg::ACT_STEP,  9'd0,   8'd0,   9'd0,   8'd0,   16'h0000, 0, 0, '0},
            '{blpg_pkg::ACT_START, 9'd300, 8'd0,   9'd0,   8'd3,   16'h5A5A, 0, 0, '0},
            '{blpg_pkg::ACT_STEP,  9'd0,   8'd0,   9'd0,   8'd0,   16'h0000, 0, 0, '0},
            '{blpg_pkg::ACT_STEP,  9'd0,   8'd0,   9'd0,   8'd0,   16'h0000, 0, 0, '0},
            // end point beyond the screen is still drawn
            '{blpg_pkg::ACT_START, 9'd5,   8'd5,   9'd511, 8'd255, 16'hC3C3, 0, 0, '0},
            '{blpg_pkg::ACT_STEP,  9'd0,   8'd0,   9'd0,   8'd0,   16'h0000, 0, 0, '0},
            '{blpg_pkg::ACT_STEP,  9'd0,   8'd0,   9'd0,   8'd0,   16'h0000, 0, 0, '0}
        };

        repeat (8) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        foreach (dir_rows[i]) begin
            w = '0;
            w.sx = dir_rows[i].sx;
            w.sy = dir_rows[i].sy;
            w.ex = dir_rows[i].ex;
            w.ey = dir_rows[i].ey;
            w.color = dir_rows[i].color;
            tag = '{fixed: dir_rows[i].fixed, fixed_hit: dir_rows[i].fixed_hit,
                    px: dir_rows[i].px};
            send_beat(dir_rows[i].act, w, tag);
        end
        drain_pixels();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin wv = 511; hv = 255; end
                1: begin wv = 0;   hv = 0;   end
                4: begin
                    wv = int'(blpg_pkg::WIDTH_RESET);
                    hv = int'(blpg_pkg::HEIGHT_RESET);
                end
                5: begin wv = 511; hv = 0;   end
                default: begin
                    wv = int'($urandom_range(0, 511));
                    hv = int'($urandom_range(0, 255));
                end
            endcase
            write_reg(blpg_pkg::CFG_SCREEN_WIDTH, wv);
            write_reg(blpg_pkg::CFG_SCREEN_HEIGHT, hv);
            // long output hold-off so the block backs up into its input
            if (p == 0 || p == 3) hold_requests++;
            phase_beats = 0;
            while (phase_beats < BEATS_PER_PHASE) begin
                if ($urandom_range(0, 9) < 8) send_line();
                else send_noise();
            end
            drain_pixels();
        end

        if (fail_count == 0) begin
            $display("** bresenham_line_pixel_generator: PASSED **");
        end else begin
            $display("** bresenham_line_pixel_generator: FAILED **");
        end
        $finish;
    end

endmodule
